// File: rtl/fpc_pkg.sv
package fpc_pkg;

   // plane order: left, right, top, bottom, near, far
   localparam int PLANE_COUNT = 6;
   localparam int VEC_COUNT   = 4;

   // field widths
   localparam int VEC_W       = 64;
   localparam int ELEM_W      = 16;
   localparam int COEF_W      = ELEM_W + 1;
   localparam int POINT_W     = 24;
   localparam int PROD_W      = COEF_W + POINT_W;
   localparam int DTERM_SHIFT = 8;
   localparam int DIST_W      = PROD_W + 3;
   localparam int CSR_INDEX_W = 8;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_VECTOR_0 = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_VECTOR_1 = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_VECTOR_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_VECTOR_3 = CSR_INDEX_W'(3);

   // input stage, product, partial sum, distance, result
   localparam int PIPE_DEPTH = 5;

   // which vector is combined with vector 3 per plane, and whether it is subtracted
   localparam logic [1:0] PLANE_VEC [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic       PLANE_NEG [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [POINT_W-1:0] point_type;

   typedef struct packed {
      coef_type a;
      coef_type b;
      coef_type c;
      coef_type d;
   } plane_type;

endpackage

// File: rtl/fpc_coef.sv
module fpc_coef (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [fpc_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [fpc_pkg::VEC_W-1:0]       wr_data,
   output fpc_pkg::plane_type             planes [fpc_pkg::PLANE_COUNT]
);
   import fpc_pkg::*;

   logic [VEC_W-1:0] matrix_ff [VEC_COUNT];
   logic [VEC_W-1:0] matrix_in [VEC_COUNT];
   plane_type        planes_ff [PLANE_COUNT];
   plane_type        planes_in [PLANE_COUNT];

   // sign-extend two q4.12 entries and add or subtract without loss
   function automatic coef_type combine(input logic [ELEM_W-1:0] base,
                                        input logic [ELEM_W-1:0] other,
                                        input logic              neg);
      coef_type b_ext;
      coef_type o_ext;
      b_ext = COEF_W'($signed(base));
      o_ext = COEF_W'($signed(other));
      return neg ? coef_type'(b_ext - o_ext) : coef_type'(b_ext + o_ext);
   endfunction

   // matrix register writes, out-of-range indexes dropped
   always_comb begin
      for (int v = 0; v < VEC_COUNT; v++) begin
         matrix_in[v] = matrix_ff[v];
      end
      if (wr_en) begin
         case (wr_index)
            CSR_MATRIX_VECTOR_0: matrix_in[0] = wr_data;
            CSR_MATRIX_VECTOR_1: matrix_in[1] = wr_data;
            CSR_MATRIX_VECTOR_2: matrix_in[2] = wr_data;
            CSR_MATRIX_VECTOR_3: matrix_in[3] = wr_data;
            default: ;
         endcase
      end
   end

   // plane extraction from vector 3 plus or minus one other vector
   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         planes_in[p].a = combine(matrix_ff[3][0*ELEM_W +: ELEM_W],
                                  matrix_ff[PLANE_VEC[p]][0*ELEM_W +: ELEM_W], PLANE_NEG[p]);
         planes_in[p].b = combine(matrix_ff[3][1*ELEM_W +: ELEM_W],
                                  matrix_ff[PLANE_VEC[p]][1*ELEM_W +: ELEM_W], PLANE_NEG[p]);
         planes_in[p].c = combine(matrix_ff[3][2*ELEM_W +: ELEM_W],
                                  matrix_ff[PLANE_VEC[p]][2*ELEM_W +: ELEM_W], PLANE_NEG[p]);
         planes_in[p].d = combine(matrix_ff[3][3*ELEM_W +: ELEM_W],
                                  matrix_ff[PLANE_VEC[p]][3*ELEM_W +: ELEM_W], PLANE_NEG[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VEC_COUNT; v++) begin
            matrix_ff[v] <= '0;
         end
         for (int p = 0; p < PLANE_COUNT; p++) begin
            planes_ff[p] <= '0;
         end
      end else begin
         matrix_ff <= matrix_in;
         planes_ff <= planes_in;
      end
   end

   assign planes = planes_ff;

endmodule

// File: rtl/fpc_dot.sv
module fpc_dot (
   input  logic                 clock,
   input  fpc_pkg::plane_type   plane,
   input  fpc_pkg::point_type   px,
   input  fpc_pkg::point_type   py,
   input  fpc_pkg::point_type   pz,
   output logic                 outside,
   output logic                 zero_dist
);
   import fpc_pkg::*;

   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [DIST_W-1:0] sum_xy_ff, sum_zd_ff;
   logic signed [DIST_W-1:0] sum_xy_in, sum_zd_in;
   logic signed [DIST_W-1:0] dist_ff, dist_in;
   logic signed [COEF_W+DTERM_SHIFT-1:0] dterm;

   // stage 1: one multiplier per coordinate
   assign prod_x_in = PROD_W'(plane.a) * PROD_W'(px);
   assign prod_y_in = PROD_W'(plane.b) * PROD_W'(py);
   assign prod_z_in = PROD_W'(plane.c) * PROD_W'(pz);

   // d at product scale; user holds plane static while points flow, unenforced
   assign dterm = {plane.d, {DTERM_SHIFT{1'b0}}};

   // stage 2: pairwise sums
   assign sum_xy_in = DIST_W'(prod_x_ff) + DIST_W'(prod_y_ff);
   assign sum_zd_in = DIST_W'(prod_z_ff) + DIST_W'(dterm);

   // stage 3: full signed distance
   assign dist_in = sum_xy_ff + sum_zd_ff;

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      sum_xy_ff <= sum_xy_in;
      sum_zd_ff <= sum_zd_in;
      dist_ff   <= dist_in;
   end

   // sign and zero test on the registered distance
   assign outside   = dist_ff[DIST_W-1];
   assign zero_dist = (dist_ff == '0);

endmodule

// File: rtl/frustum_point_cull.sv
// Frustum point culling. Each point is tested against the six planes taken from a
// view-projection matrix (four 64-bit vectors of signed Q4.12 entries written
// through the csr port at indexes 0 to 3; other indexes are ignored). One point
// is taken every clock: busy never rises. The result passes the input register,
// the 18 multipliers, two adder stages and the result register and appears on
// rsp_valid in order, for exactly one cycle; the receiver cannot hold it off,
// so it must take every strobed word. The distance sums are exact.
// A matrix write takes effect for points started from the next cycle on; write
// only while no point is in flight.
module frustum_point_cull (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  fpc_pkg::point_type              req_point_x,
   input  fpc_pkg::point_type              req_point_y,
   input  fpc_pkg::point_type              req_point_z,
   output logic                            rsp_valid,
   output logic                            rsp_visible,
   output logic [fpc_pkg::PLANE_COUNT-1:0] rsp_outside_mask,
   output logic [fpc_pkg::PLANE_COUNT-1:0] rsp_on_plane_mask,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpc_pkg::VEC_W-1:0]       csr_data
);
   import fpc_pkg::*;

   logic                   accept;
   logic [PIPE_DEPTH-1:0]  valid_ff, valid_in;
   point_type              px_ff, py_ff, pz_ff;
   plane_type              planes [PLANE_COUNT];
   logic [PLANE_COUNT-1:0] outside_in, zero_in;
   logic [PLANE_COUNT-1:0] outside_ff, zero_ff;
   logic                   visible_ff;

   // fully pipelined, never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // matrix registers and plane table
   fpc_coef u_coef (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .planes   (planes)
   );

   // input word register
   always_ff @(posedge clock) begin
      px_ff <= req_point_x;
      py_ff <= req_point_y;
      pz_ff <= req_point_z;
   end

   // one distance pipeline per plane
   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fpc_dot u_dot (
         .clock     (clock),
         .plane     (planes[p]),
         .px        (px_ff),
         .py        (py_ff),
         .pz        (pz_ff),
         .outside   (outside_in[p]),
         .zero_dist (zero_in[p])
      );
   end

   // valid bits travel alongside the data stages
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      outside_ff <= outside_in;
      zero_ff    <= zero_in;
      visible_ff <= (outside_in == '0);
   end

   assign rsp_valid         = valid_ff[PIPE_DEPTH-1];
   assign rsp_visible       = visible_ff;
   assign rsp_outside_mask  = outside_ff;
   assign rsp_on_plane_mask = zero_ff;

endmodule

// File: rtl/fpc_check.sv
module fpc_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic                            rsp_visible,
   input logic [fpc_pkg::PLANE_COUNT-1:0] rsp_outside_mask,
   input logic [fpc_pkg::PLANE_COUNT-1:0] rsp_on_plane_mask
);
   import fpc_pkg::*;

   // every accepted word comes back after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(PIPE_DEPTH) rsp_valid)
      else $error("accepted word produced no result");

   // no result without a matching accepted word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without accepted word");

   // visible exactly when no plane is failed
   a_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_visible == (rsp_outside_mask == '0)))
      else $error("visible flag disagrees with outside mask");

   // a distance cannot be both negative and zero
   a_masks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_outside_mask & rsp_on_plane_mask) == '0))
      else $error("plane flagged both outside and on plane");

endmodule

bind frustum_point_cull fpc_check u_check (.*);

// File: tb/sv/frustum_point_cull_checker.sv
`timescale 1ns / 100ps

// watches the point, csr and result channels, predicts each result word and compares
module frustum_point_cull_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  fpc_pkg::point_type              req_point_x,
   input  fpc_pkg::point_type              req_point_y,
   input  fpc_pkg::point_type              req_point_z,
   input  logic                            rsp_valid,
   input  logic                            rsp_visible,
   input  logic [fpc_pkg::PLANE_COUNT-1:0] rsp_outside_mask,
   input  logic [fpc_pkg::PLANE_COUNT-1:0] rsp_on_plane_mask,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [fpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpc_pkg::VEC_W-1:0]       csr_data,
   output int                              fail_count,
   output int                              words_pending
);
   import fpc_pkg::*;

   localparam int COEF_COUNT   = 4;
   localparam int BASE_VEC     = VEC_COUNT - 1;
   // planes that subtract their partner vector: right, top, far
   localparam logic [PLANE_COUNT-1:0] SUBTRACT_MASK = 6'b100110;

   typedef struct packed {
      logic                   visible;
      logic [PLANE_COUNT-1:0] outside;
      logic [PLANE_COUNT-1:0] touching;
   } cull_word_type;

   logic [VEC_W-1:0] matrix_vec [VEC_COUNT];
   cull_word_type    expected_words [$];

   initial begin
      fail_count    = 0;
      words_pending = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t cull check: %s", $time, msg);
      fail_count++;
   endtask

   // exact plane distances for one point against the current matrix
   function automatic cull_word_type predict_cull(input point_type px, input point_type py,
                                                  input point_type pz);
      cull_word_type            word;
      coef_type                 coef [COEF_COUNT];
      logic signed [ELEM_W-1:0] base_elem;
      logic signed [ELEM_W-1:0] partner_elem;
      longint                   plane_dist;
      word = '0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         for (int j = 0; j < COEF_COUNT; j++) begin
            base_elem    = matrix_vec[BASE_VEC][ELEM_W*j +: ELEM_W];
            // planes pair up on vectors 0, 1, 2
            partner_elem = matrix_vec[p >> 1][ELEM_W*j +: ELEM_W];
            coef[j] = SUBTRACT_MASK[p] ? coef_type'(base_elem) - coef_type'(partner_elem)
                                       : coef_type'(base_elem) + coef_type'(partner_elem);
         end
         plane_dist = longint'(coef[0]) * longint'(px) + longint'(coef[1]) * longint'(py)
                    + longint'(coef[2]) * longint'(pz)
                    + longint'(coef[3]) * (longint'(1) <<< DTERM_SHIFT);
         if (plane_dist < 0) begin
            word.outside[p] = 1'b1;
         end else if (plane_dist == 0) begin
            word.touching[p] = 1'b1;
         end
      end
      word.visible = (word.outside == '0);
      return word;
   endfunction

   // track matrix writes, queue predictions, compare result words
   always @(posedge clock) begin
      cull_word_type got_word;
      cull_word_type want_word;
      if (reset) begin
         expected_words.delete();
         for (int v = 0; v < VEC_COUNT; v++) begin
            matrix_vec[v] = '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATRIX_VECTOR_0: matrix_vec[0] = csr_data;
               CSR_MATRIX_VECTOR_1: matrix_vec[1] = csr_data;
               CSR_MATRIX_VECTOR_2: matrix_vec[2] = csr_data;
               CSR_MATRIX_VECTOR_3: matrix_vec[3] = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_words.push_back(predict_cull(req_point_x, req_point_y, req_point_z));
         end
         if (rsp_valid !== 1'b0) begin
            got_word = {rsp_visible, rsp_outside_mask, rsp_on_plane_mask};
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("result word with none expected: vis %b out %b on %b",
                                         got_word.visible, got_word.outside,
                                         got_word.touching));
            end else begin
               want_word = expected_words.pop_front();
               if (got_word.visible !== want_word.visible ||
                   got_word.outside !== want_word.outside ||
                   got_word.touching !== want_word.touching) begin
                  report_mismatch($sformatf(
                     "word mismatch: vis %b/%b out %b/%b on %b/%b (got/exp)",
                     got_word.visible, want_word.visible, got_word.outside,
                     want_word.outside, got_word.touching, want_word.touching));
               end
            end
         end
      end
      words_pending <= expected_words.size();
   end

endmodule

// File: tb/sv/frustum_point_cull_tb.sv
`timescale 1ns / 100ps

module frustum_point_cull_tb;
   import fpc_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 2 * PIPE_DEPTH;
   localparam int ITEMS_PER_PHASE = 222;
   localparam int REGIME_COUNT    = 3;
   localparam int IDLE_LIGHT      = 13;
   localparam int IDLE_HEAVY      = 61;
   localparam int PCT_RANGE       = 99;

   localparam logic [ELEM_W-1:0] ONE_Q412 = 16'h1000;
   localparam logic [ELEM_W-1:0] ELEM_MAX = 16'h7FFF;
   localparam logic [ELEM_W-1:0] ELEM_MIN = 16'h8000;
   localparam point_type UNIT_Q168 = 24'sd256;
   localparam point_type TWO_Q168  = 24'sd512;
   localparam point_type POINT_MAX = 24'sh7FFFFF;
   localparam point_type POINT_MIN = 24'sh800000;

   typedef enum int {MATRIX_RANDOM, MATRIX_EXTREME, MATRIX_INTEGER} matrix_style_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   point_type              req_point_x;
   point_type              req_point_y;
   point_type              req_point_z;
   logic                   rsp_valid;
   logic                   rsp_visible;
   logic [PLANE_COUNT-1:0] rsp_outside_mask;
   logic [PLANE_COUNT-1:0] rsp_on_plane_mask;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [VEC_W-1:0]       csr_data;
   int                     fail_count;
   int                     words_pending;
   int                     quiet_cycles;

   frustum_point_cull dut (.*);

   frustum_point_cull_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stall watchdog: cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("frustum_point_cull_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [VEC_W-1:0] pack_vector(input logic [ELEM_W-1:0] e0,
                                                    input logic [ELEM_W-1:0] e1,
                                                    input logic [ELEM_W-1:0] e2,
                                                    input logic [ELEM_W-1:0] e3);
      return {e3, e2, e1, e0};
   endfunction

   // matrix vector with entries of the given flavor
   function automatic logic [VEC_W-1:0] make_vector(input matrix_style_type style);
      logic [VEC_W-1:0] vec;
      vec = '0;
      for (int j = 0; j < VEC_W / ELEM_W; j++) begin
         case (style)
            MATRIX_RANDOM: vec[ELEM_W*j +: ELEM_W] = ELEM_W'($urandom);
            MATRIX_EXTREME: begin
               case ($urandom_range(4))
                  0: vec[ELEM_W*j +: ELEM_W] = ELEM_MAX;
                  1: vec[ELEM_W*j +: ELEM_W] = ELEM_MIN;
                  2: vec[ELEM_W*j +: ELEM_W] = '0;
                  3: vec[ELEM_W*j +: ELEM_W] = '1;
                  default: vec[ELEM_W*j +: ELEM_W] = ELEM_W'(1);
               endcase
            end
            default: begin
               // whole numbers so that planes land on grid points
               vec[ELEM_W*j +: ELEM_W] = ELEM_W'((int'($urandom_range(6)) - 3) * int'(ONE_Q412));
            end
         endcase
      end
      return vec;
   endfunction

   // coordinate mix: full range, grid points, near origin, extremes
   function automatic point_type random_coord();
      point_type coord;
      case ($urandom_range(9))
         0, 1, 2, 3: coord = point_type'($urandom);
         4, 5, 6:    coord = point_type'((int'($urandom_range(8)) - 4) * int'(UNIT_Q168));
         7, 8:       coord = point_type'(int'($urandom_range(4095)) - 2048);
         default: begin
            case ($urandom_range(3))
               0: coord = POINT_MAX;
               1: coord = POINT_MIN;
               2: coord = '0;
               default: coord = '1;
            endcase
         end
      endcase
      return coord;
   endfunction

   // csr_valid stays high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [VEC_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic load_matrix(input logic [VEC_W-1:0] v0, input logic [VEC_W-1:0] v1,
                              input logic [VEC_W-1:0] v2, input logic [VEC_W-1:0] v3);
      write_csr(CSR_MATRIX_VECTOR_0, v0);
      write_csr(CSR_MATRIX_VECTOR_1, v1);
      write_csr(CSR_MATRIX_VECTOR_2, v2);
      write_csr(CSR_MATRIX_VECTOR_3, v3);
      // unused index now and then, must change nothing
      if ($urandom_range(1) == 1) begin
         write_csr(CSR_INDEX_W'($urandom_range(VEC_COUNT, (1 << CSR_INDEX_W) - 1)),
                   {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
   endtask

   // start stays high across back-to-back words
   task automatic send_point(input point_type x, input point_type y, input point_type z,
                             input int idle_pct);
      while (int'($urandom_range(PCT_RANGE)) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
   endtask

   initial begin
      int idle_pct;
      reset       = 1'b1;
      start       = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero matrix after reset: every plane passes through every point
      send_point(POINT_MAX, POINT_MAX, POINT_MAX, 0);
      send_point(POINT_MIN, POINT_MIN, POINT_MIN, 0);
      send_point('0, '0, '0, 0);
      wait_idle();

      // write to an unused index leaves the matrix at zero
      write_csr(CSR_INDEX_W'(VEC_COUNT), '1);
      csr_valid <= 1'b0;
      @(negedge clock);
      send_point(UNIT_Q168, -UNIT_Q168, UNIT_Q168, 0);
      wait_idle();

      // identity matrix: unit cube, points inside, on and beyond each plane
      load_matrix(pack_vector(ONE_Q412, '0, '0, '0), pack_vector('0, ONE_Q412, '0, '0),
                  pack_vector('0, '0, ONE_Q412, '0), pack_vector('0, '0, '0, ONE_Q412));
      @(negedge clock);
      send_point('0, '0, '0, 0);
      send_point(-UNIT_Q168, '0, '0, 0);
      send_point(UNIT_Q168, '0, '0, 0);
      send_point('0, UNIT_Q168, '0, 0);
      send_point('0, -UNIT_Q168, '0, 0);
      send_point('0, '0, -UNIT_Q168, 0);
      send_point('0, '0, UNIT_Q168, 0);
      send_point(-TWO_Q168, '0, '0, 0);
      send_point(TWO_Q168, '0, '0, 0);
      send_point('0, TWO_Q168, '0, 0);
      send_point('0, -TWO_Q168, '0, 0);
      send_point('0, '0, -TWO_Q168, 0);
      send_point('0, '0, TWO_Q168, 0);
      send_point(UNIT_Q168, UNIT_Q168, UNIT_Q168, 0);
      wait_idle();

      // extreme entries: largest positive and negative coefficients
      load_matrix({4{ELEM_MIN}}, {4{ELEM_MIN}}, {4{ELEM_MIN}}, {4{ELEM_MAX}});
      @(negedge clock);
      send_point(POINT_MAX, POINT_MAX, POINT_MAX, 0);
      send_point(POINT_MIN, POINT_MIN, POINT_MIN, 0);
      wait_idle();
      load_matrix({4{ELEM_MIN}}, {4{ELEM_MIN}}, {4{ELEM_MIN}}, {4{ELEM_MIN}});
      @(negedge clock);
      send_point(POINT_MAX, POINT_MIN, POINT_MAX, 0);
      send_point(POINT_MIN, POINT_MAX, POINT_MIN, 0);
      wait_idle();

      // random points under several matrices, light, heavy, then no sender idling
      for (int r = 0; r < REGIME_COUNT; r++) begin
         idle_pct = (r == 0) ? IDLE_LIGHT : (r == 1) ? IDLE_HEAVY : 0;
         for (int m = 0; m < 3; m++) begin
            load_matrix(make_vector(matrix_style_type'(m)), make_vector(matrix_style_type'(m)),
                        make_vector(matrix_style_type'(m)), make_vector(matrix_style_type'(m)));
            @(negedge clock);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
               send_point(random_coord(), random_coord(), random_coord(), idle_pct);
            end
            wait_idle();
         end
      end

      // let any stray word show up before the verdict
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("frustum_point_cull_tb: PASS");
      end else begin
         $display("frustum_point_cull_tb: FAIL");
      end
      $finish;
   end

endmodule
